// File: sv/mqpd_pkg.sv
// Shared types and constants for the multi-queue priority dispatcher.
package mqpd_pkg;

  // Fixed field widths of the channel words.
  localparam int KEY_W    = 8;
  localparam int WEIGHT_W = 8;
  localparam int QSEL_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_OUT_W  = 5;
  localparam int LOAD_OUT_W = 12;
  localparam int ENTRY_W  = KEY_W + WEIGHT_W;

  // Action codes.
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_ENQ   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DEQ   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic                action;
    logic [KEY_W-1:0]    priority_key;
    logic [WEIGHT_W-1:0] job_weight;
    logic [QSEL_W-1:0]   queue_select;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [QSEL_W-1:0]     served_queue;
    logic [KEY_W-1:0]      result_key;
    logic [WEIGHT_W-1:0]   result_weight;
    logic [CNT_OUT_W-1:0]  entries_left;
    logic [LOAD_OUT_W-1:0] load_left;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_INS_MV,
    S_INS_LAST,
    S_DQ_CHECK,
    S_DQ_HEAD,
    S_DQ_MV,
    S_DONE
  } state_t;

endpackage

// File: sv/mqpd_in_if.sv
// Input channel interface carrying one request word.
interface mqpd_in_if;
  logic               valid;
  logic               ready;
  mqpd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/mqpd_out_if.sv
// Result channel interface carrying one result word.
interface mqpd_out_if;
  logic                valid;
  logic                ready;
  mqpd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/mqpd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mqpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mqpd_core.sv
// Sequencer for least-loaded placement, sorted insertion and head removal.
module mqpd_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_QUEUES  = 4,
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  mqpd_pkg::in_word_t  in_data,
  output logic                in_ready,
  output logic                res_valid,
  output mqpd_pkg::out_word_t res_data,
  input  logic                res_take,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output mqpd_pkg::entry_t    ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  mqpd_pkg::entry_t    ram_rdata
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = $clog2(QUEUE_DEPTH * 255 + 1);

  mqpd_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r  [NUM_QUEUES];
  logic [CW-1:0] cnt_nxt [NUM_QUEUES];
  logic [LW-1:0] load_r [NUM_QUEUES];
  logic [LW-1:0] load_nxt [NUM_QUEUES];

  logic [QW-1:0] idx_r, idx_nxt;
  logic [QW-1:0] bq_r, bq_nxt;
  logic [LW-1:0] best_r, best_nxt;
  logic [CW-1:0] slot_r, slot_nxt;
  logic [mqpd_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [mqpd_pkg::WEIGHT_W-1:0] wt_r, wt_nxt;
  mqpd_pkg::out_word_t res_r, res_nxt;

  logic [CW-1:0] cur_cnt;
  logic [LW-1:0] cur_load;
  logic [CW-1:0] enq_cnt, deq_cnt;
  logic [LW-1:0] enq_load, deq_load, deq_w;
  logic [mqpd_pkg::KEY_W-1:0]    deq_key;
  logic [mqpd_pkg::WEIGHT_W-1:0] deq_wt;
  logic          scan_take;
  logic          qsel_bad;
  mqpd_pkg::entry_t new_entry;

  function automatic logic [AW-1:0] addr_of(logic [QW-1:0] q, logic [CW-1:0] s);
    return AW'(int'(q) * QUEUE_DEPTH + int'(s));
  endfunction

  assign cur_cnt  = cnt_r[idx_r];
  assign cur_load = load_r[idx_r];
  assign enq_cnt  = cur_cnt + CW'(1);
  assign enq_load = cur_load + LW'(wt_r);
  assign deq_cnt  = cur_cnt - CW'(1);
  assign deq_key  = (state_r == mqpd_pkg::S_DQ_HEAD) ? ram_rdata.key : key_r;
  assign deq_wt   = (state_r == mqpd_pkg::S_DQ_HEAD) ? ram_rdata.weight : wt_r;
  assign deq_w    = LW'(deq_wt);
  assign deq_load = (cur_load >= deq_w) ? (cur_load - deq_w) : '0;
  assign scan_take = (idx_r == '0) || (cur_load < best_r);
  assign qsel_bad  = int'(in_data.queue_select) >= NUM_QUEUES;
  assign new_entry = '{key: key_r, weight: wt_r};

  assign in_ready  = (state_r == mqpd_pkg::S_IDLE);
  assign res_valid = (state_r == mqpd_pkg::S_DONE);
  assign res_data  = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mqpd_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == mqpd_pkg::ACT_ENQ) state_nxt = mqpd_pkg::S_SCAN;
          else if (qsel_bad) state_nxt = mqpd_pkg::S_DONE;
          else state_nxt = mqpd_pkg::S_DQ_CHECK;
        end
      end
      mqpd_pkg::S_SCAN: begin
        if (idx_r == QW'(NUM_QUEUES - 1)) state_nxt = mqpd_pkg::S_CHECK;
      end
      mqpd_pkg::S_CHECK: begin
        if (cur_cnt >= CW'(QUEUE_DEPTH) || cur_cnt == '0) state_nxt = mqpd_pkg::S_DONE;
        else state_nxt = mqpd_pkg::S_INS_MV;
      end
      mqpd_pkg::S_INS_MV: begin
        if (ram_rdata.key > key_r) state_nxt = mqpd_pkg::S_DONE;
        else if (slot_r == CW'(1)) state_nxt = mqpd_pkg::S_INS_LAST;
      end
      mqpd_pkg::S_INS_LAST: state_nxt = mqpd_pkg::S_DONE;
      mqpd_pkg::S_DQ_CHECK: begin
        if (cur_cnt == '0) state_nxt = mqpd_pkg::S_DONE;
        else state_nxt = mqpd_pkg::S_DQ_HEAD;
      end
      mqpd_pkg::S_DQ_HEAD: begin
        if (cur_cnt == CW'(1)) state_nxt = mqpd_pkg::S_DONE;
        else state_nxt = mqpd_pkg::S_DQ_MV;
      end
      mqpd_pkg::S_DQ_MV: begin
        if (slot_r == deq_cnt) state_nxt = mqpd_pkg::S_DONE;
      end
      mqpd_pkg::S_DONE: begin
        if (res_take) state_nxt = mqpd_pkg::S_IDLE;
      end
      default: state_nxt = mqpd_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory accesses and result word.
  always_comb begin
    cnt_nxt   = cnt_r;
    load_nxt  = load_r;
    idx_nxt   = idx_r;
    bq_nxt    = bq_r;
    best_nxt  = best_r;
    slot_nxt  = slot_r;
    key_nxt   = key_r;
    wt_nxt    = wt_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = addr_of(idx_r, slot_r);
    ram_wdata = new_entry;
    ram_raddr = addr_of(idx_r, '0);
    unique case (state_r)
      mqpd_pkg::S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_data.priority_key;
          wt_nxt  = in_data.job_weight;
          if (in_data.action == mqpd_pkg::ACT_ENQ) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = QW'(in_data.queue_select);
            res_nxt = '{status: mqpd_pkg::STAT_EMPTY, served_queue: in_data.queue_select,
                        default: '0};
          end
        end
      end
      mqpd_pkg::S_SCAN: begin
        if (scan_take) begin
          best_nxt = cur_load;
          bq_nxt   = idx_r;
        end
        if (idx_r == QW'(NUM_QUEUES - 1)) idx_nxt = scan_take ? idx_r : bq_r;
        else idx_nxt = idx_r + QW'(1);
      end
      mqpd_pkg::S_CHECK: begin
        if (cur_cnt >= CW'(QUEUE_DEPTH)) begin
          res_nxt = '{status: mqpd_pkg::STAT_FULL,
                      served_queue: mqpd_pkg::QSEL_W'(idx_r),
                      result_key: '0, result_weight: '0,
                      entries_left: mqpd_pkg::CNT_OUT_W'(cur_cnt),
                      load_left: mqpd_pkg::LOAD_OUT_W'(cur_load)};
        end else if (cur_cnt == '0) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(idx_r, '0);
        end else begin
          ram_raddr = addr_of(idx_r, deq_cnt);
          slot_nxt  = cur_cnt;
        end
      end
      mqpd_pkg::S_INS_MV: begin
        ram_we = 1'b1;
        if (!(ram_rdata.key > key_r)) begin
          ram_wdata = ram_rdata;
          slot_nxt  = slot_r - CW'(1);
          ram_raddr = addr_of(idx_r, slot_r - CW'(2));
        end
      end
      mqpd_pkg::S_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(idx_r, '0);
      end
      mqpd_pkg::S_DQ_CHECK: begin
        res_nxt = '{status: mqpd_pkg::STAT_EMPTY,
                    served_queue: mqpd_pkg::QSEL_W'(idx_r),
                    result_key: '0, result_weight: '0, entries_left: '0,
                    load_left: mqpd_pkg::LOAD_OUT_W'(cur_load)};
      end
      mqpd_pkg::S_DQ_HEAD: begin
        key_nxt   = ram_rdata.key;
        wt_nxt    = ram_rdata.weight;
        ram_raddr = addr_of(idx_r, CW'(1));
        slot_nxt  = CW'(1);
      end
      mqpd_pkg::S_DQ_MV: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(idx_r, slot_r - CW'(1));
        ram_wdata = ram_rdata;
        ram_raddr = addr_of(idx_r, slot_r + CW'(1));
        slot_nxt  = slot_r + CW'(1);
      end
      mqpd_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase

    // Completion of an enqueue that stored its entry.
    if ((state_r == mqpd_pkg::S_CHECK && cur_cnt == '0) ||
        (state_r == mqpd_pkg::S_INS_MV && ram_rdata.key > key_r) ||
        state_r == mqpd_pkg::S_INS_LAST) begin
      cnt_nxt[idx_r]  = enq_cnt;
      load_nxt[idx_r] = enq_load;
      res_nxt = '{status: mqpd_pkg::STAT_ENQ,
                  served_queue: mqpd_pkg::QSEL_W'(idx_r),
                  result_key: '0, result_weight: '0,
                  entries_left: mqpd_pkg::CNT_OUT_W'(enq_cnt),
                  load_left: mqpd_pkg::LOAD_OUT_W'(enq_load)};
    end

    // Completion of a dequeue once the tail has moved up.
    if ((state_r == mqpd_pkg::S_DQ_HEAD && cur_cnt == CW'(1)) ||
        (state_r == mqpd_pkg::S_DQ_MV && slot_r == deq_cnt)) begin
      cnt_nxt[idx_r]  = deq_cnt;
      load_nxt[idx_r] = deq_load;
      res_nxt = '{status: mqpd_pkg::STAT_DEQ,
                  served_queue: mqpd_pkg::QSEL_W'(idx_r),
                  result_key: deq_key, result_weight: deq_wt,
                  entries_left: mqpd_pkg::CNT_OUT_W'(deq_cnt),
                  load_left: mqpd_pkg::LOAD_OUT_W'(deq_load)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mqpd_pkg::S_IDLE;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i]  <= '0;
        load_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      load_r  <= load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    bq_r   <= bq_nxt;
    best_r <= best_nxt;
    slot_r <= slot_nxt;
    key_r  <= key_nxt;
    wt_r   <= wt_nxt;
    res_r  <= res_nxt;
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != mqpd_pkg::S_IDLE))
    else $error("accepted word did not start work");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mqpd_pkg::S_CHECK) |-> (cur_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == mqpd_pkg::S_INS_MV || state_r == mqpd_pkg::S_DQ_MV))
      |-> (ram_waddr != ram_raddr))
    else $error("shift wrote the entry it is reading");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (res_valid && $stable(res_data)))
    else $error("pending result changed");
`endif

endmodule

// File: sv/multi_queue_priority_dispatch.sv
// Multi-queue priority dispatch.
// An enqueue scans NUM_QUEUES loads one per cycle, then shifts keys that are not larger back one entry
// per cycle through the single read and single write port of the entry memory.
// A dequeue reads the head, then moves each remaining entry forward one per cycle.
// One request is in work at a time; a result waits in the output register while the next
// request is taken. Synchronous active-low reset clears counts, loads and control state.
module multi_queue_priority_dispatch #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_QUEUES  = 4
) (
  input logic       clk,
  input logic       rst_n,
  mqpd_in_if.sink   in_chan,
  mqpd_out_if.source out_chan
);

  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  // Result handoff between the sequencer and the output register.
  logic                res_valid;
  logic                res_take;
  mqpd_pkg::out_word_t res_data;

  // Entry memory port.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  mqpd_pkg::entry_t    ram_wdata;
  mqpd_pkg::entry_t    ram_rdata;
  logic [mqpd_pkg::ENTRY_W-1:0] ram_rdata_raw;

  // Output register: a finished word sits here until the sink takes it, so the
  // sequencer can already work on the next request.
  logic                obuf_v_r, obuf_v_nxt;
  mqpd_pkg::out_word_t obuf_r, obuf_nxt;

  assign ram_rdata = mqpd_pkg::entry_t'(ram_rdata_raw);

  mqpd_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_data   (in_chan.data),
    .in_ready  (in_chan.ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // All queues share one memory; queue q owns a block of QUEUE_DEPTH entries, entry 0 is its head.
  mqpd_ram #(
    .WIDTH (mqpd_pkg::ENTRY_W),
    .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  // The sequencer hands over a word when the register is empty or being drained.
  assign res_take = res_valid && (!obuf_v_r || out_chan.ready);

  always_comb begin
    obuf_v_nxt = obuf_v_r;
    obuf_nxt   = obuf_r;
    if (out_chan.ready) obuf_v_nxt = 1'b0;
    if (res_take) begin
      obuf_v_nxt = 1'b1;
      obuf_nxt   = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obuf_v_r <= 1'b0;
    end else begin
      obuf_v_r <= obuf_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obuf_r <= obuf_nxt;
  end

  assign out_chan.valid = obuf_v_r;
  assign out_chan.data  = obuf_r;

endmodule

// File: tb/sv/testbench.sv
// Testbench for the multi-queue priority dispatcher: random traffic checked against a predictor.
module testbench;

  localparam int NQ = 4;
  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;

  mqpd_in_if  in_chan ();
  mqpd_out_if out_chan ();

  multi_queue_priority_dispatch #(.QUEUE_DEPTH(DEPTH), .NUM_QUEUES(NQ)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  // The dispatch predictor keeps its own copy of every queue. It updates that copy for each
  // request word the block takes, and queues the result word the block should return.
  class dispatch_scoreboard;
    mqpd_pkg::entry_t    slots[NQ][DEPTH];
    int                  fill[NQ];
    int                  weight_sum[NQ];
    mqpd_pkg::out_word_t pending[$];
    int                  mismatches;

    function void clear();
      for (int q = 0; q < NQ; q++) begin
        fill[q] = 0;
        weight_sum[q] = 0;
      end
      pending.delete();
      mismatches = 0;
    endfunction

    // Picks the least-loaded queue; equal loads go to the lowest index.
    function int lightest_queue();
      int q;
      q = 0;
      for (int i = 1; i < NQ; i++)
        if (weight_sum[i] < weight_sum[q]) q = i;
      return q;
    endfunction

    function void note_request(mqpd_pkg::in_word_t w);
      mqpd_pkg::out_word_t r;
      int q;
      int pos;
      r = '0;
      if (w.action == mqpd_pkg::ACT_ENQ) begin
        q = lightest_queue();
        r.served_queue = mqpd_pkg::QSEL_W'(q);
        if (fill[q] >= DEPTH) begin
          r.status = mqpd_pkg::STAT_FULL;
        end else begin
          // The new entry goes ahead of every entry whose key is not larger.
          pos = 0;
          while (pos < fill[q] && slots[q][pos].key > w.priority_key) pos++;
          for (int i = fill[q]; i > pos; i--) slots[q][i] = slots[q][i-1];
          slots[q][pos].key = w.priority_key;
          slots[q][pos].weight = w.job_weight;
          fill[q]++;
          weight_sum[q] += w.job_weight;
          r.status = mqpd_pkg::STAT_ENQ;
        end
      end else begin
        q = w.queue_select;
        r.served_queue = mqpd_pkg::QSEL_W'(q);
        if (fill[q] == 0) begin
          r.status = mqpd_pkg::STAT_EMPTY;
        end else begin
          r.status = mqpd_pkg::STAT_DEQ;
          r.result_key = slots[q][0].key;
          r.result_weight = slots[q][0].weight;
          for (int i = 1; i < fill[q]; i++) slots[q][i-1] = slots[q][i];
          fill[q]--;
          weight_sum[q] -= r.result_weight;
          if (weight_sum[q] < 0) weight_sum[q] = 0;
        end
      end
      r.entries_left = mqpd_pkg::CNT_OUT_W'(fill[q]);
      r.load_left = mqpd_pkg::LOAD_OUT_W'(weight_sum[q]);
      pending.push_back(r);
    endfunction

    function void check_result(mqpd_pkg::out_word_t got);
      mqpd_pkg::out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.served_queue !== want.served_queue ||
          got.result_key !== want.result_key || got.result_weight !== want.result_weight ||
          got.entries_left !== want.entries_left || got.load_left !== want.load_left) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                   want.status, want.served_queue, want.result_key, want.result_weight,
                   want.entries_left, want.load_left, got.status, got.served_queue,
                   got.result_key, got.result_weight, got.entries_left, got.load_left);
      end
    endfunction
  endclass

  dispatch_scoreboard board;
  int  idle_cycles;
  bit  sending_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input words are offered at the falling edge; the block takes them at the rising edge.
  task automatic send_word(mqpd_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.data  <= w;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    board.note_request(w);
    @(negedge clk);
  endtask

  task automatic send_enq(logic [7:0] key, logic [7:0] weight);
    mqpd_pkg::in_word_t w;
    w = '0;
    w.action = mqpd_pkg::ACT_ENQ;
    w.priority_key = key;
    w.job_weight = weight;
    w.queue_select = mqpd_pkg::QSEL_W'($urandom_range(0, 3));
    send_word(w);
  endtask

  task automatic send_deq(logic [1:0] q);
    mqpd_pkg::in_word_t w;
    w.action = mqpd_pkg::ACT_DEQ;
    w.priority_key = 8'($urandom_range(0, 255));
    w.job_weight = 8'($urandom_range(0, 255));
    w.queue_select = q;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // The result side drops ready for a random gap, possibly none, before it takes each word.
  initial begin
    int gap;
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_chan.valid));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) board.check_result(out_chan.data);
  end

  // The watchdog counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int mode;
    board = new();
    board.clear();
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty dequeues, extreme fields, equal keys, single-entry dequeue.
    for (int q = 0; q < NQ; q++) send_deq(2'(q));
    send_enq(8'd0, 8'd0);
    send_deq(2'd0);
    send_enq(8'd255, 8'd255);
    send_enq(8'd255, 8'd1);
    send_enq(8'd7, 8'd0);
    send_enq(8'd7, 8'd0);
    send_enq(8'd7, 8'd3);
    send_enq(8'h55, 8'hAA);
    send_enq(8'hAA, 8'h55);
    for (int q = 0; q < NQ; q++) send_deq(2'(q));
    // Enqueue zero-weight entries so the least-loaded pick stays on queue 0, which fills and then reports full.
    for (int i = 0; i < DEPTH + 2; i++) send_enq(8'($urandom_range(0, 255)), 8'd0);
    wait_drained();
    for (int i = 0; i < DEPTH + 1; i++) send_deq(2'd0);
    for (int q = 1; q < NQ; q++) while (board.fill[q] > 0) send_deq(2'(q));

    // Random part: phases lean toward enqueue, dequeue or balanced traffic.
    for (int i = 0; i < 495; i++) begin
      if (i % 80 == 0) mode = $urandom_range(0, 2);
      if (i == 260) wait_drained();
      if ($urandom_range(0, 9) < (mode == 0 ? 7 : mode == 1 ? 3 : 5))
        send_enq(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0) ? 8'd0 :
                 8'($urandom_range(0, 255)));
      else
        send_deq(2'($urandom_range(0, 3)));
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mqpd_pkg.sv
sv/mqpd_in_if.sv
sv/mqpd_out_if.sv
sv/mqpd_ram.sv
sv/mqpd_core.sv
sv/multi_queue_priority_dispatch.sv
tb/sv/testbench.sv
